// ===== rtl/core/gll_pkg.sv =====
// Shared types, constants and character helpers of the GLL sentence parser.
package gll_pkg;

    // Longest line, in characters without the line feed, that is not too long.
    localparam int unsigned MAX_LINE = 82;
    localparam logic [6:0] MAX_LINE_LEN = 7'(MAX_LINE);

    // Reset values of the configuration registers.
    localparam logic [6:0] MIN_LENGTH_RESET   = 7'd49;
    localparam logic       CHECK_ENABLE_RESET = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_MIN_LENGTH   = 1'b0;
    localparam logic CFG_CHECK_ENABLE = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM   = 2'd1;
    localparam logic [1:0] STATUS_MALFORMED = 2'd2;

    // Angle magnitude limits in units of 1/600000 degree.
    localparam logic [26:0] LAT_MAX = 27'd54000000;
    localparam logic [27:0] LON_MAX = 28'd108000000;

    // Character codes.
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    // Depth of the queue between the classifier and the parser.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One classified character as it travels through the queue.
    typedef struct packed {
        logic [7:0] chr;
        logic       is_lf;
        logic       is_dollar;
        logic       is_star;
        logic       is_comma;
        logic       is_south;
        logic       is_west;
        logic [3:0] digit;
        logic       hex_ok;
        logic [3:0] hex;
    } gll_char_t;

    function automatic gll_char_t classify(input logic [7:0] c);
        gll_char_t r;
        r.chr       = c;
        r.is_lf     = (c == CH_LF);
        r.is_dollar = (c == CH_DOLLAR);
        r.is_star   = (c == CH_STAR);
        r.is_comma  = (c == CH_COMMA);
        r.is_south  = (c == CH_S);
        r.is_west   = (c == CH_W);
        r.digit     = 4'd0;
        r.hex_ok    = 1'b0;
        r.hex       = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.digit  = 4'(c - 8'h30);
            r.hex_ok = 1'b1;
            r.hex    = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.hex_ok = 1'b1;
            r.hex    = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.hex_ok = 1'b1;
            r.hex    = 4'(c - 8'h57);
        end
        return r;
    endfunction

    // Expected header character after the dollar sign, "GPGLL".
    function automatic logic [7:0] tag_char(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0:    r = 8'h47;
            3'd1:    r = 8'h50;
            3'd2:    r = 8'h47;
            3'd3:    r = 8'h4C;
            3'd4:    r = 8'h4C;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Contribution of one latitude digit at its position in ddmm.mmmm.
    function automatic logic [26:0] lat_term(input logic [3:0] pos, input logic [3:0] d);
        logic [26:0] w;
        case (pos)
            4'd0:    w = 27'd6000000;
            4'd1:    w = 27'd600000;
            4'd2:    w = 27'd100000;
            4'd3:    w = 27'd10000;
            4'd5:    w = 27'd1000;
            4'd6:    w = 27'd100;
            4'd7:    w = 27'd10;
            4'd8:    w = 27'd1;
            default: w = 27'd0;
        endcase
        return 27'(w * 27'(d));
    endfunction

    // Contribution of one longitude digit at its position in dddmm.mmmm.
    function automatic logic [29:0] lon_term(input logic [3:0] pos, input logic [3:0] d);
        logic [29:0] w;
        case (pos)
            4'd0:    w = 30'd60000000;
            4'd1:    w = 30'd6000000;
            4'd2:    w = 30'd600000;
            4'd3:    w = 30'd100000;
            4'd4:    w = 30'd10000;
            4'd6:    w = 30'd1000;
            4'd7:    w = 30'd100;
            4'd8:    w = 30'd10;
            4'd9:    w = 30'd1;
            default: w = 30'd0;
        endcase
        return 30'(w * 30'(d));
    endfunction

endpackage

// ===== rtl/core/gll_front.sv =====
// Front end: classifies incoming characters and queues them for the parser.
module gll_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_stall,
    input  logic [7:0]          rx_byte,
    output logic                q_valid,
    output gll_pkg::gll_char_t  q_item,
    input  logic                q_pop
);

    localparam logic [gll_pkg::QUEUE_AW:0] QUEUE_FULL = (gll_pkg::QUEUE_AW + 1)'(gll_pkg::QUEUE_DEPTH);

    gll_pkg::gll_char_t                  queue_mem [gll_pkg::QUEUE_DEPTH];
    logic [gll_pkg::QUEUE_AW-1:0]        wr_ptr_reg;
    logic [gll_pkg::QUEUE_AW-1:0]        wr_ptr_next;
    logic [gll_pkg::QUEUE_AW-1:0]        rd_ptr_reg;
    logic [gll_pkg::QUEUE_AW-1:0]        rd_ptr_next;
    logic [gll_pkg::QUEUE_AW:0]          count_reg;
    logic [gll_pkg::QUEUE_AW:0]          count_next;
    logic                                push;
    logic                                pop;

    assign rx_stall = (count_reg == QUEUE_FULL);
    assign push     = rx_valid && !rx_stall;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= gll_pkg::classify(rx_byte);
        end
    end

    // The occupancy never exceeds the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_FULL)
        else $error("queue count above depth");

    // A push and no pop into a full queue never happens.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QUEUE_FULL && !pop) |=> (count_reg == QUEUE_FULL))
        else $error("queue overflowed");

    // Popping an empty queue never happens.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !pop)
        else $error("queue underflowed");

endmodule

// ===== rtl/core/gll_back.sv =====
// Back end: GLL sentence state machine, field decoding and the result register.
module gll_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  gll_pkg::gll_char_t  q_item,
    output logic                q_pop,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [6:0]          cfg_data,
    output logic                res_valid,
    input  logic                res_stall,
    output logic signed [26:0]  latitude,
    output logic signed [27:0]  longitude,
    output logic [6:0]          fix_hours,
    output logic [6:0]          fix_minutes,
    output logic [6:0]          fix_seconds,
    output logic [1:0]          status
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY,
        PH_SUM_HI,
        PH_SUM_LO,
        PH_SUM_DONE,
        PH_SUM_BAD
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [2:0]          header_pos_reg, header_pos_next;
    logic [3:0]          field_index_reg, field_index_next;
    logic [3:0]          char_in_field_reg, char_in_field_next;
    logic [6:0]          line_length_reg, line_length_next;
    logic [7:0]          xor_sum_reg, xor_sum_next;
    logic [7:0]          sent_sum_reg, sent_sum_next;
    logic [26:0]         lat_accum_reg, lat_accum_next;
    logic [27:0]         lon_accum_reg, lon_accum_next;
    logic [1:0]          hemisphere_reg, hemisphere_next;
    logic [6:0]          hours_reg, hours_next;
    logic [6:0]          minutes_reg, minutes_next;
    logic [6:0]          seconds_reg, seconds_next;
    logic [6:0]          min_length_reg;
    logic                check_enable_reg;

    logic                res_valid_reg;
    logic signed [26:0]  latitude_reg;
    logic signed [27:0]  longitude_reg;
    logic [6:0]          fix_hours_reg;
    logic [6:0]          fix_minutes_reg;
    logic [6:0]          fix_seconds_reg;
    logic [1:0]          status_reg;

    logic                pop;
    logic                in_sentence;
    logic                emit;
    logic [1:0]          status_calc;
    logic [27:0]         lat_sum;
    logic [29:0]         lon_sum;
    logic [6:0]          tens;
    logic [6:0]          pair_sel;

    assign cfg_ready   = 1'b1;
    assign pop         = q_valid && !(q_item.is_lf && res_valid_reg && res_stall);
    assign q_pop       = pop;
    assign in_sentence = (phase_reg != PH_IDLE) && (phase_reg != PH_HEADER);
    assign emit        = pop && q_item.is_lf && in_sentence;

    assign lat_sum  = {1'b0, lat_accum_reg}
                    + {1'b0, gll_pkg::lat_term(char_in_field_reg, q_item.digit)};
    assign lon_sum  = {2'b00, lon_accum_reg}
                    + gll_pkg::lon_term(char_in_field_reg, q_item.digit);
    assign tens     = 7'(q_item.digit * 4'd10);

    always_comb
    begin
        case (char_in_field_reg[2:1])
            2'd0:    pair_sel = hours_reg;
            2'd1:    pair_sel = minutes_reg;
            default: pair_sel = seconds_reg;
        endcase
    end

    always_comb
    begin
        if (line_length_reg <= min_length_reg || line_length_reg > gll_pkg::MAX_LINE_LEN
            || phase_reg == PH_BODY)
        begin
            status_calc = gll_pkg::STATUS_MALFORMED;
        end
        else if (check_enable_reg
                 && (phase_reg != PH_SUM_DONE || sent_sum_reg != xor_sum_reg))
        begin
            status_calc = gll_pkg::STATUS_BAD_SUM;
        end
        else
        begin
            status_calc = gll_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        header_pos_next    = header_pos_reg;
        field_index_next   = field_index_reg;
        char_in_field_next = char_in_field_reg;
        line_length_next   = line_length_reg;
        xor_sum_next       = xor_sum_reg;
        sent_sum_next      = sent_sum_reg;
        lat_accum_next     = lat_accum_reg;
        lon_accum_next     = lon_accum_reg;
        hemisphere_next    = hemisphere_reg;
        hours_next         = hours_reg;
        minutes_next       = minutes_reg;
        seconds_next       = seconds_reg;

        if (pop)
        begin
            if (q_item.is_lf || q_item.is_dollar)
            begin
                header_pos_next    = '0;
                field_index_next   = '0;
                char_in_field_next = '0;
                xor_sum_next       = '0;
                sent_sum_next      = '0;
                lat_accum_next     = '0;
                lon_accum_next     = '0;
                hemisphere_next    = '0;
                hours_next         = '0;
                minutes_next       = '0;
                seconds_next       = '0;
            end

            if (q_item.is_lf)
            begin
                phase_next       = PH_IDLE;
                line_length_next = '0;
            end
            else
            begin
                if (line_length_reg != 7'h7F)
                begin
                    line_length_next = line_length_reg + 1'b1;
                end

                if (q_item.is_dollar)
                begin
                    phase_next = PH_HEADER;
                end
                else
                begin
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            xor_sum_next = xor_sum_reg ^ q_item.chr;
                            if (q_item.chr == gll_pkg::tag_char(header_pos_reg))
                            begin
                                header_pos_next = header_pos_reg + 1'b1;
                                if (header_pos_reg == 3'd4)
                                begin
                                    phase_next = PH_BODY;
                                end
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_BODY:
                        begin
                            if (q_item.is_star)
                            begin
                                phase_next = PH_SUM_HI;
                            end
                            else
                            begin
                                xor_sum_next = xor_sum_reg ^ q_item.chr;
                                if (q_item.is_comma)
                                begin
                                    if (field_index_reg != 4'hF)
                                    begin
                                        field_index_next = field_index_reg + 1'b1;
                                    end
                                    char_in_field_next = '0;
                                end
                                else
                                begin
                                    case (field_index_reg)
                                        4'd1:
                                        begin
                                            if (char_in_field_reg < 4'd9)
                                            begin
                                                lat_accum_next = (lat_sum > {1'b0, gll_pkg::LAT_MAX})
                                                               ? gll_pkg::LAT_MAX : lat_sum[26:0];
                                            end
                                        end
                                        4'd2:
                                        begin
                                            hemisphere_next[0] = (char_in_field_reg == 4'd0)
                                                               && q_item.is_south;
                                        end
                                        4'd3:
                                        begin
                                            if (char_in_field_reg < 4'd10)
                                            begin
                                                lon_accum_next = (lon_sum > {2'b00, gll_pkg::LON_MAX})
                                                               ? gll_pkg::LON_MAX : lon_sum[27:0];
                                            end
                                        end
                                        4'd4:
                                        begin
                                            hemisphere_next[1] = (char_in_field_reg == 4'd0)
                                                               && q_item.is_west;
                                        end
                                        4'd5:
                                        begin
                                            if (char_in_field_reg < 4'd6)
                                            begin
                                                case (char_in_field_reg[2:1])
                                                    2'd0:
                                                    begin
                                                        hours_next = char_in_field_reg[0]
                                                            ? 7'(pair_sel + 7'(q_item.digit)) : tens;
                                                    end
                                                    2'd1:
                                                    begin
                                                        minutes_next = char_in_field_reg[0]
                                                            ? 7'(pair_sel + 7'(q_item.digit)) : tens;
                                                    end
                                                    default:
                                                    begin
                                                        seconds_next = char_in_field_reg[0]
                                                            ? 7'(pair_sel + 7'(q_item.digit)) : tens;
                                                    end
                                                endcase
                                            end
                                        end
                                        default:
                                        begin
                                        end
                                    endcase
                                    if (char_in_field_reg != 4'hF)
                                    begin
                                        char_in_field_next = char_in_field_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        PH_SUM_HI:
                        begin
                            if (q_item.hex_ok)
                            begin
                                sent_sum_next = {q_item.hex, 4'h0};
                                phase_next    = PH_SUM_LO;
                            end
                            else
                            begin
                                phase_next = PH_SUM_BAD;
                            end
                        end
                        PH_SUM_LO:
                        begin
                            if (q_item.hex_ok)
                            begin
                                sent_sum_next = {sent_sum_reg[7:4], q_item.hex};
                                phase_next    = PH_SUM_DONE;
                            end
                            else
                            begin
                                phase_next = PH_SUM_BAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            header_pos_reg    <= '0;
            field_index_reg   <= '0;
            char_in_field_reg <= '0;
            line_length_reg   <= '0;
            xor_sum_reg       <= '0;
            sent_sum_reg      <= '0;
            lat_accum_reg     <= '0;
            lon_accum_reg     <= '0;
            hemisphere_reg    <= '0;
            hours_reg         <= '0;
            minutes_reg       <= '0;
            seconds_reg       <= '0;
            min_length_reg    <= gll_pkg::MIN_LENGTH_RESET;
            check_enable_reg  <= gll_pkg::CHECK_ENABLE_RESET;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            header_pos_reg    <= header_pos_next;
            field_index_reg   <= field_index_next;
            char_in_field_reg <= char_in_field_next;
            line_length_reg   <= line_length_next;
            xor_sum_reg       <= xor_sum_next;
            sent_sum_reg      <= sent_sum_next;
            lat_accum_reg     <= lat_accum_next;
            lon_accum_reg     <= lon_accum_next;
            hemisphere_reg    <= hemisphere_next;
            hours_reg         <= hours_next;
            minutes_reg       <= minutes_next;
            seconds_reg       <= seconds_next;
            res_valid_reg     <= emit || (res_valid_reg && res_stall);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gll_pkg::CFG_MIN_LENGTH:   min_length_reg   <= cfg_data;
                    gll_pkg::CFG_CHECK_ENABLE: check_enable_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            latitude_reg    <= hemisphere_reg[0] ? -$signed(lat_accum_reg) : $signed(lat_accum_reg);
            longitude_reg   <= hemisphere_reg[1] ? -$signed(lon_accum_reg) : $signed(lon_accum_reg);
            fix_hours_reg   <= hours_reg;
            fix_minutes_reg <= minutes_reg;
            fix_seconds_reg <= seconds_reg;
            status_reg      <= status_calc;
        end
    end

    assign res_valid   = res_valid_reg;
    assign latitude    = latitude_reg;
    assign longitude   = longitude_reg;
    assign fix_hours   = fix_hours_reg;
    assign fix_minutes = fix_minutes_reg;
    assign fix_seconds = fix_seconds_reg;
    assign status      = status_reg;

    // A line feed is never consumed while a held result still waits.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.is_lf) |-> !(res_valid_reg && res_stall))
        else $error("result overwritten");

    // While matching the header, fewer than five tag characters have been seen.
    a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (header_pos_reg < 3'd5))
        else $error("header position out of range");

    // A consumed line feed restarts the line count and the parser.
    a_lf_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.is_lf) |=> (line_length_reg == '0 && phase_reg == PH_IDLE))
        else $error("line feed did not restart the parser");

    // The angle accumulators never pass their limits.
    a_angle_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (lat_accum_reg <= gll_pkg::LAT_MAX) && (lon_accum_reg <= gll_pkg::LON_MAX))
        else $error("angle accumulator above limit");

    // A fresh result carries a defined status code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> (status_reg != 2'd3))
        else $error("undefined status code");

endmodule

// ===== rtl/core/nmea_gll_sentence_parser.sv =====
// Top level of the NMEA 0183 GLL sentence parser.
// The parser takes one receiver character per transaction on the rx channel and
// can accept a new character in every clock cycle unless the queue is full. A
// classifier stage decodes each character (line feed, dollar, star, comma,
// hemisphere letters, decimal digit, hex digit) and places it into a four-entry
// queue; the parser state machine behind it consumes one character per cycle
// unless a line feed waits on the held result, and registers each result when
// the closing line feed of its line is popped from the queue. The result
// sits in an output register: only a line feed that arrives while the previous
// result is still held and stalled makes the parser wait, and the queue keeps
// accepting characters until it fills. Each line feed that closes a line with a
// $GPGLL header gives one result transaction: signed latitude and longitude in
// units of 1/600000 degree (south and west negative), the hhmmss fix time as
// three two-digit values, and a status of ok, checksum mismatch, or malformed
// (too short, too long or no star). Angles and time are reported even with a
// bad status. The two configuration registers (minimum length, index 0, reset
// 49; checksum check enable, index 1, reset 1) are written through the cfg
// channel, which is always ready, and should only be changed while no line is
// in flight.
module nmea_gll_sentence_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_stall,
    input  logic [7:0]          rx_byte,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [6:0]          cfg_data,
    output logic                res_valid,
    input  logic                res_stall,
    output logic signed [26:0]  latitude,
    output logic signed [27:0]  longitude,
    output logic [6:0]          fix_hours,
    output logic [6:0]          fix_minutes,
    output logic [6:0]          fix_seconds,
    output logic [1:0]          status
);

    // Classified characters waiting for the parser.
    logic                q_valid;
    gll_pkg::gll_char_t  q_item;
    logic                q_pop;

    // Front: character classification and the decoupling queue.
    gll_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_byte  (rx_byte),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Back: sentence state machine, field decoding, configuration and result.
    gll_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .latitude    (latitude),
        .longitude   (longitude),
        .fix_hours   (fix_hours),
        .fix_minutes (fix_minutes),
        .fix_seconds (fix_seconds),
        .status      (status)
    );

endmodule

// ===== bench/nmea_gll_sentence_parser_tb.sv =====
// Self-checking testbench for the NMEA GLL sentence parser: directed and random lines.
module nmea_gll_sentence_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gll_pkg::*;

    // The run is bounded by this many clock cycles.
    localparam int unsigned CYCLE_LIMIT = 500000;

    // Carriage return, sent before most line feeds of random lines just as a receiver does.
    localparam logic [7:0] CH_CR = 8'h0D;

    // The five characters that must follow the dollar sign.
    localparam logic [39:0] GLL_TAG = "GPGLL";

    // Phases of the bench's own sentence scanner.
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_TAG,
        SCAN_FIELDS,
        SCAN_SUM_HI,
        SCAN_SUM_LO,
        SCAN_SUM_OK,
        SCAN_SUM_BAD
    } gll_scan_t;

    // One decoded position fix, as the result channel should present it.
    typedef struct packed {
        logic [26:0] lat;
        logic [27:0] lon;
        logic [6:0]  hours;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic [1:0]  status;
    } gll_fix_t;

    logic clk;
    logic rst_n = 1'b0;

    logic rx_valid = 1'b0;
    logic rx_stall;
    logic [7:0] rx_byte = 8'h00;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [6:0] cfg_data = 7'd0;

    logic res_valid;
    logic res_stall = 1'b0;
    logic signed [26:0] latitude;
    logic signed [27:0] longitude;
    logic [6:0] fix_hours;
    logic [6:0] fix_minutes;
    logic [6:0] fix_seconds;
    logic [1:0] status;

    // Percent of cycles in which the character sender holds back, and in which the
    // result receiver stalls. The main sequence changes both between phases.
    int unsigned send_idle_pct;
    int unsigned stall_pct;

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned fixes_predicted = 0;

    // Fixes that the scanner has predicted and the block has not yet delivered.
    gll_fix_t pending_fixes[$];
    gll_fix_t oldest_fix;
    string fix_diff;

    // Copy of the configuration registers, updated when a write transaction completes.
    logic [6:0] min_length_q;
    logic       check_enable_q;

    // Scanner state: where the sentence stands and what has been decoded so far.
    gll_scan_t   scan;
    logic [2:0]  tag_pos;
    logic [3:0]  field_idx;
    logic [3:0]  char_pos;
    logic [6:0]  line_len;
    logic [7:0]  run_sum;
    logic [7:0]  given_sum;
    int unsigned lat_mag;
    int unsigned lon_mag;
    logic [1:0]  hemi;          // bit 0 south, bit 1 west
    logic [6:0]  clock_pair [3]; // hours, minutes, seconds

    nmea_gll_sentence_parser i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .latitude    (latitude),
        .longitude   (longitude),
        .fix_hours   (fix_hours),
        .fix_minutes (fix_minutes),
        .fix_seconds (fix_seconds),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Scanner: a cycle-free description of what the parser must report.
    // ------------------------------------------------------------------

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "A" && c <= "F")
            return c - "A" + 10;
        if (c >= "a" && c <= "f")
            return c - "a" + 10;
        return -1;
    endfunction

    // Weight of one latitude digit in ddmm.mmmm; the '.' position weighs nothing.
    function automatic int unsigned lat_weight_of(input logic [3:0] pos);
        case (pos)
            4'd0:    return 6000000;
            4'd1:    return 600000;
            4'd2:    return 100000;
            4'd3:    return 10000;
            4'd5:    return 1000;
            4'd6:    return 100;
            4'd7:    return 10;
            4'd8:    return 1;
            default: return 0;
        endcase
    endfunction

    // Longitude carries one more degree digit in front, the rest lines up with latitude.
    function automatic int unsigned lon_weight_of(input logic [3:0] pos);
        return (pos == 4'd0) ? 60000000 : lat_weight_of(pos - 4'd1);
    endfunction

    function automatic void clear_decode();
        tag_pos   = '0;
        field_idx = '0;
        char_pos  = '0;
        run_sum   = '0;
        given_sum = '0;
        lat_mag   = 0;
        lon_mag   = 0;
        hemi      = '0;
        for (int k = 0; k < 3; k++)
            clock_pair[k] = '0;
    endfunction

    function automatic void reset_scanner();
        min_length_q   = MIN_LENGTH_RESET;
        check_enable_q = CHECK_ENABLE_RESET;
        scan           = SCAN_IDLE;
        line_len       = '0;
        clear_decode();
    endfunction

    // A character inside a field, neither comma nor star.
    function automatic void decode_field_char(input logic [7:0] c);
        logic [3:0] d;
        d = (c >= "0" && c <= "9") ? 4'(c - "0") : 4'd0;
        case (field_idx)
            4'd1:
                if (char_pos < 4'd9)
                begin
                    lat_mag = lat_mag + d * lat_weight_of(char_pos);
                    if (lat_mag > LAT_MAX)
                        lat_mag = LAT_MAX;
                end
            4'd2:
                hemi[0] = (char_pos == 4'd0 && c == CH_S);
            4'd3:
                if (char_pos < 4'd10)
                begin
                    lon_mag = lon_mag + d * lon_weight_of(char_pos);
                    if (lon_mag > LON_MAX)
                        lon_mag = LON_MAX;
                end
            4'd4:
                hemi[1] = (char_pos == 4'd0 && c == CH_W);
            4'd5:
                if (char_pos < 4'd6)
                begin
                    if (!char_pos[0])
                        clock_pair[char_pos[2:1]] = 7'(d * 7'd10);
                    else
                        clock_pair[char_pos[2:1]] = 7'(clock_pair[char_pos[2:1]] + d);
                end
            default: ;
        endcase
        if (char_pos != 4'd15)
            char_pos++;
    endfunction

    // Advances the scanner by one accepted character and queues the fix that a line
    // feed closing a GLL line produces.
    function automatic void parse_byte(input logic [7:0] c);
        gll_fix_t fix;
        int hv;
        if (c == CH_LF)
        begin
            if (scan != SCAN_IDLE && scan != SCAN_TAG)
            begin
                if (line_len <= min_length_q || line_len > MAX_LINE_LEN || scan == SCAN_FIELDS)
                    fix.status = STATUS_MALFORMED;
                else if (check_enable_q && (scan != SCAN_SUM_OK || given_sum != run_sum))
                    fix.status = STATUS_BAD_SUM;
                else
                    fix.status = STATUS_OK;
                fix.lat     = 27'(hemi[0] ? 32'd0 - lat_mag : lat_mag);
                fix.lon     = 28'(hemi[1] ? 32'd0 - lon_mag : lon_mag);
                fix.hours   = clock_pair[0];
                fix.minutes = clock_pair[1];
                fix.seconds = clock_pair[2];
                pending_fixes.push_back(fix);
                fixes_predicted++;
            end
            scan     = SCAN_IDLE;
            line_len = '0;
            clear_decode();
        end
        else
        begin
            if (line_len != 7'd127)
                line_len++;
            if (c == CH_DOLLAR)
            begin
                // A dollar sign anywhere starts over, but the line length keeps running.
                clear_decode();
                scan = SCAN_TAG;
            end
            else
            begin
                hv = hex_nibble(c);
                case (scan)
                    SCAN_TAG:
                    begin
                        run_sum ^= c;
                        if (tag_pos < 3'd5 && c == GLL_TAG[39 - 8 * tag_pos -: 8])
                        begin
                            tag_pos++;
                            if (tag_pos == 3'd5)
                                scan = SCAN_FIELDS;
                        end
                        else
                            scan = SCAN_IDLE;
                    end
                    SCAN_FIELDS:
                        if (c == CH_STAR)
                            scan = SCAN_SUM_HI;
                        else
                        begin
                            run_sum ^= c;
                            if (c == CH_COMMA)
                            begin
                                if (field_idx != 4'd15)
                                    field_idx++;
                                char_pos = '0;
                            end
                            else
                                decode_field_char(c);
                        end
                    SCAN_SUM_HI:
                        if (hv >= 0)
                        begin
                            given_sum = {hv[3:0], 4'h0};
                            scan      = SCAN_SUM_LO;
                        end
                        else
                            scan = SCAN_SUM_BAD;
                    SCAN_SUM_LO:
                        if (hv >= 0)
                        begin
                            given_sum[3:0] = hv[3:0];
                            scan           = SCAN_SUM_OK;
                        end
                        else
                            scan = SCAN_SUM_BAD;
                    default: ;
                endcase
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall and comparison against the oldest fix.
    // ------------------------------------------------------------------

    function automatic string field_diff(input string name, input logic signed [31:0] want,
                                         input logic signed [31:0] got);
        if (got !== want)
            return $sformatf(" %s expected %0d got %0d", name, want, got);
        return "";
    endfunction

    // A result transaction completes at an edge where res_valid is high and res_stall
    // low. Both are read just after the edge, before any update of that edge lands.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_fixes.size() == 0)
                note_error($sformatf("result with no line pending: lat %0d lon %0d status %0d",
                                     latitude, longitude, status));
            else
            begin
                oldest_fix = pending_fixes.pop_front();
                fix_diff = {field_diff("latitude", $signed(oldest_fix.lat), latitude),
                            field_diff("longitude", $signed(oldest_fix.lon), longitude),
                            field_diff("fix_hours", oldest_fix.hours, fix_hours),
                            field_diff("fix_minutes", oldest_fix.minutes, fix_minutes),
                            field_diff("fix_seconds", oldest_fix.seconds, fix_seconds),
                            field_diff("status", oldest_fix.status, status)};
                if (fix_diff != "")
                    note_error({"result mismatch:", fix_diff});
            end
        end
        res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Backstop against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("nmea_gll_sentence_parser_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------

    // Offers one character and holds it until the rx transaction completes. Valid is
    // only lowered during an idle gap, so back-to-back characters keep it high.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= c;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        parse_byte(c);
    endtask

    // Sends a line and its closing line feed.
    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        send_char(CH_LF);
    endtask

    // Waits until every predicted fix has been delivered. A line that gives no result
    // may still sit in the block's queue then, so a short pause follows.
    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        rx_valid <= 1'b0;
        while (pending_fixes.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_fixes.size() != 0)
        begin
            note_error($sformatf("%0d predicted fixes never arrived", pending_fixes.size()));
            pending_fixes.delete();
        end
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_MIN_LENGTH)
            min_length_q = data;
        else
            check_enable_q = data[0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Registers change only with the block idle. The enable register gets random upper
    // bits, which must not matter.
    task automatic set_config(input logic [6:0] min_len, input logic enable);
        wait_idle();
        write_reg(CFG_MIN_LENGTH, min_len);
        write_reg(CFG_CHECK_ENABLE, {6'($urandom_range(0, 63)), enable});
    endtask

    // ------------------------------------------------------------------
    // Sentence building.
    // ------------------------------------------------------------------

    function automatic logic [7:0] nmea_xor(input string body);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < body.len(); i++)
            acc ^= body[i];
        return acc;
    endfunction

    function automatic string with_sum(input string body);
        return {"$", body, $sformatf("*%02X", nmea_xor(body))};
    endfunction

    // A well-formed GLL body padded with a trailing field to n characters; the full
    // sentence with dollar sign and checksum is then n + 4 characters long.
    function automatic string sized_body(input int n);
        string s;
        s = "GPGLL,4916.4500,N,12311.1200,W,225444.00,A";
        if (n > s.len())
        begin
            s = {s, ","};
            while (s.len() < n)
                s = {s, "Z"};
        end
        return s;
    endfunction

    function automatic string decimal_digits(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    // A printable character that cannot open, split or close a sentence.
    function automatic string junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(32, 126));
        while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA);
        return $sformatf("%c", c);
    endfunction

    function automatic string garbled_field();
        string s;
        int n;
        s = "";
        n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++)
            case ($urandom_range(0, 3))
                0, 1:    s = {s, decimal_digits(1)};
                2:       s = {s, "."};
                default: s = {s, junk_char()};
            endcase
        return s;
    endfunction

    function automatic string hemisphere(input string pos, input string neg);
        case ($urandom_range(0, 19))
            0:       return "";
            1:       return {neg, junk_char()};
            2:       return junk_char();
            default: return ($urandom_range(0, 1) != 0) ? neg : pos;
        endcase
    endfunction

    // One random line: mostly a GLL sentence with random content and a checksum in any
    // of its good and bad forms, sometimes a broken header, sometimes raw noise.
    task automatic send_random_line();
        string lead, tag, lat, lon, ns, ew, tod, tail, body, line;
        logic [7:0] sum;
        int roll;
        int n;
        if ($urandom_range(0, 99) < 8)
        begin
            // Raw bytes over the whole code range; a stray line feed just ends a line.
            n = $urandom_range(0, 40);
            for (int i = 0; i < n; i++)
                send_char(8'($urandom_range(0, 255)));
            send_char(CH_LF);
        end
        else
        begin
            case ($urandom_range(0, 24))
                0:       tag = "GPGGA";
                1:       tag = "GPGL";
                2:       tag = "GNGLL";
                default: tag = "GPGLL";
            endcase
            lat = ($urandom_range(0, 99) < 85) ? {decimal_digits(4), ".", decimal_digits(4)}
                                               : garbled_field();
            lon = ($urandom_range(0, 99) < 85) ? {decimal_digits(5), ".", decimal_digits(4)}
                                               : garbled_field();
            ns  = hemisphere("N", "S");
            ew  = hemisphere("E", "W");
            tod = decimal_digits(6);
            if ($urandom_range(0, 1) != 0)
                tod = {tod, ".00"};
            if ($urandom_range(0, 9) == 0)
                tod = garbled_field();
            case ($urandom_range(0, 3))
                0:       tail = "";
                1:       tail = ",A";
                2:       tail = ",A,A";
                default: tail = ",V,N";
            endcase
            // Now and then a line that runs past the longest allowed length.
            if ($urandom_range(0, 29) == 0)
                repeat ($urandom_range(3, 10)) tail = {tail, ",", decimal_digits(8)};
            body = {tag, ",", lat, ",", ns, ",", lon, ",", ew, ",", tod, tail};
            sum  = nmea_xor(body);
            roll = $urandom_range(0, 99);
            if (roll < 70)
                line = {"$", body, $sformatf("*%02X", sum)};
            else if (roll < 78)
                line = {"$", body, $sformatf("*%02x", sum)};
            else if (roll < 86)
                line = {"$", body, $sformatf("*%02X", sum ^ 8'($urandom_range(1, 255)))};
            else if (roll < 90)
                line = {"$", body, $sformatf("*%0X", sum[7:4])};
            else if (roll < 94)
                line = {"$", body, "*", junk_char(), $sformatf("%0X", sum[3:0])};
            else
                line = {"$", body};
            lead = "";
            if ($urandom_range(0, 9) == 0)
                lead = {junk_char(), junk_char()};
            if ($urandom_range(0, 19) == 0)
                lead = {lead, "$GPGLL,", decimal_digits(3)};
            line = {lead, line};
            if ($urandom_range(0, 9) != 0)
                line = {line, $sformatf("%c", CH_CR)};
            send_line(line);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset configuration: a line of exactly the minimum length is too short, one
    // character more passes, and the checksum is checked.
    task automatic test_reset_config();
        send_line(with_sum(sized_body(45)));
        send_line(with_sum(sized_body(46)));
        send_line({"$", sized_body(46), "*00"});
    endtask

    // Checksum forms: lower case digits, a wrong sum, missing and non-hex digits, no
    // star at all, then a wrong sum and no star again with checking switched off.
    task automatic test_checksum_forms();
        string b;
        logic [7:0] sum;
        b   = "GPGLL,3751.6500,S,14507.3600,E,092750.00,A";
        sum = nmea_xor(b);
        set_config(7'd0, 1'b1);
        send_line({"$", b, $sformatf("*%02x", sum)});
        send_line({"$", b, $sformatf("*%02X", sum ^ 8'h01)});
        send_line({"$", b, $sformatf("*%0X", sum[7:4])});
        send_line({"$", b, "*G", $sformatf("%0X", sum[3:0])});
        send_line({"$", b, $sformatf("*%0Xg", sum[7:4])});
        send_line({"$", b});
        set_config(7'd0, 1'b0);
        send_line({"$", b, $sformatf("*%02X", ~sum)});
        send_line({"$", b});
    endtask

    // Field decoding: zero and largest real angles, saturation of both angles, empty
    // fields, non-digits, loose hemisphere letters, and fields or field counts past
    // what the counters hold.
    task automatic test_field_decoding();
        set_config(7'd0, 1'b1);
        send_line(with_sum("GPGLL,0000.0000,S,00000.0000,W,000000,A"));
        send_line(with_sum("GPGLL,8959.9999,S,17959.9999,W,235959.99,A"));
        send_line(with_sum("GPGLL,9999.9999,N,99999.9999,E,999999,A"));
        send_line(with_sum("GPGLL,,,,,,"));
        send_line(with_sum("GPGLL,4a16.4x00,SX,1231,W ,12:34:56,A"));
        send_line(with_sum({"GPGLL,49164500123456789012,N,12311.12009876,E,1234567890,A",
                            ",,,,,,,,,,,,,,,,,1"}));
    endtask

    // Line framing and the length limits, with the minimum length at its extremes.
    task automatic test_line_framing();
        set_config(7'd0, 1'b1);
        send_line("PLAIN TEXT WITHOUT HEADER");
        send_line("");
        send_line("$");
        send_line("$GPGLL");
        send_line(with_sum("GPGGA,123519,4807.038,N,01131.000,E"));
        send_line({"xx$GPGLL,1234.5", with_sum("GPGLL,1234.5678,N,01234.5678,E,010203,A")});
        send_line(with_sum(sized_body(124)));
        set_config(7'd127, 1'b1);
        send_line(with_sum(sized_body(46)));
        set_config(7'd82, 1'b1);
        send_line(with_sum(sized_body(78)));
        set_config(7'd81, 1'b1);
        send_line(with_sum(sized_body(78)));
        send_line(with_sum(sized_body(79)));
    endtask

    // Random lines in three idling mixes, each under its own configuration. A phase
    // runs until it has produced enough results rather than for a number of bytes.
    task automatic test_random_traffic();
        int unsigned first;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 33;
                    stall_pct     = 70;
                end
                1:
                begin
                    send_idle_pct = 70;
                    stall_pct     = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            set_config(7'($urandom_range(38, 56)), $urandom_range(0, 3) != 0);
            first = fixes_predicted;
            while (fixes_predicted - first < 16)
                send_random_line();
        end
    endtask

    initial
    begin
        send_idle_pct = 33;
        stall_pct     = 70;
        reset_scanner();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_checksum_forms();
        test_field_decoding();
        test_line_framing();
        test_random_traffic();

        wait_idle();
        if (error_count == 0)
            $display("nmea_gll_sentence_parser_tb passed");
        else
            $display("nmea_gll_sentence_parser_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gll_pkg.sv
rtl/core/gll_front.sv
rtl/core/gll_back.sv
rtl/core/nmea_gll_sentence_parser.sv
bench/nmea_gll_sentence_parser_tb.sv
